// ===== rtl/core/pra_pkg.sv =====
package pra_pkg;

  // Default geometry
  localparam int PAGE_BYTES_DEF = (2 << 8);
  localparam int MEM_BYTES_DEF  = (2 << 17);

  // Field widths
  localparam int ACTION_W = 2;
  localparam int REQ_W    = 19;
  localparam int ADDR_W   = 18;
  localparam int FREED_W  = 19;
  localparam int STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_CLEAN = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADADDR = 2'd2
  } status_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [REQ_W-1:0]    request_bytes;
    logic [ADDR_W-1:0]   free_address;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   alloc_address;
    logic [FREED_W-1:0]  freed_bytes;
  } res_t;

endpackage

// ===== rtl/core/pra_if.sv =====
// Request channel
interface pra_req_if;
  logic                          valid;
  logic                          ready;
  logic [pra_pkg::ACTION_W-1:0]  action;
  logic [pra_pkg::REQ_W-1:0]     request_bytes;
  logic [pra_pkg::ADDR_W-1:0]    free_address;

  modport source (output valid, action, request_bytes, free_address, input ready);
  modport sink   (input valid, action, request_bytes, free_address, output ready);
endinterface

// Result channel
interface pra_res_if;
  logic                          valid;
  logic                          ready;
  logic [pra_pkg::STATUS_W-1:0]  status;
  logic [pra_pkg::ADDR_W-1:0]    alloc_address;
  logic [pra_pkg::FREED_W-1:0]   freed_bytes;

  modport source (output valid, status, alloc_address, freed_bytes, input ready);
  modport sink   (input valid, status, alloc_address, freed_bytes, output ready);
endinterface

// ===== rtl/core/pra_map_ram.sv =====
module pra_map_ram #(
  parameter int DEPTH  = 512,
  parameter int IDX_W  = 9,
  parameter int DATA_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [IDX_W-1:0]  raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pra_seq.sv =====
module pra_seq #(
  parameter int PAGE_BYTES = 512,
  parameter int MEM_BYTES  = 262144,
  parameter int IDX_W      = 9,
  parameter int CNT_W      = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  pra_pkg::req_t      req,
  output logic               idle,
  output logic               done,
  input  logic               done_ready,
  output pra_pkg::res_t      res,
  output logic               map_we,
  output logic [IDX_W-1:0]   map_waddr,
  output logic [CNT_W-1:0]   map_wdata,
  output logic [IDX_W-1:0]   map_raddr,
  input  logic [CNT_W-1:0]   map_rdata
);

  import pra_pkg::*;

  localparam int NPAGES    = MEM_BYTES / PAGE_BYTES;
  localparam int BYTES_RAW = $clog2(MEM_BYTES + PAGE_BYTES + 1);
  localparam int BW        = (BYTES_RAW > REQ_W) ? BYTES_RAW : REQ_W;
  localparam bit PB_POW2   = (PAGE_BYTES & (PAGE_BYTES - 1)) == 0;
  localparam int PB_LOG    = $clog2(PAGE_BYTES);
  localparam bit ONE_PAGE  = (NPAGES == 1);

  localparam logic [BW-1:0]     PB_B   = BW'(PAGE_BYTES);
  localparam logic [BW-1:0]     MEM_B  = BW'(MEM_BYTES);
  localparam logic [IDX_W-1:0]  LAST   = IDX_W'(NPAGES - 1);
  localparam logic [IDX_W-1:0]  IDX_1  = IDX_W'(1);
  localparam logic [CNT_W-1:0]  CNT_1  = CNT_W'(1);
  localparam logic [ADDR_W-1:0] OFFS_M = ADDR_W'(PAGE_BYTES - 1);

  typedef enum logic [10:0] {
    S_INIT  = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_SCAN  = 11'b000_0000_0100,
    S_MARK  = 11'b000_0000_1000,
    S_FIND  = 11'b000_0001_0000,
    S_FLEN  = 11'b000_0010_0000,
    S_FCHK  = 11'b000_0100_0000,
    S_BACK  = 11'b000_1000_0000,
    S_CLEAR = 11'b001_0000_0000,
    S_CLEAN = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  p;          // walk pointer: init, scan, mark, back count, clear, clean
  logic [IDX_W-1:0]  idx;        // page being freed
  logic [IDX_W-1:0]  mark_end;
  logic [BW-1:0]     bytes_req;
  logic [ADDR_W-1:0] addr_req;
  logic [BW-1:0]     pbytes;     // byte offset tracking p or idx
  logic [CNT_W-1:0]  run;        // free run so far, or pages cleared
  logic [BW-1:0]     run_bytes;  // free run bytes, or bytes cleared
  logic [CNT_W-1:0]  len;
  logic [CNT_W-1:0]  modcnt;     // matching entries below, modulo len

  // Shared step unit: one map entry evaluated per cycle
  logic              ent_zero;
  logic              ent_eq;
  logic [CNT_W-1:0]  run_inc;
  logic [BW-1:0]     runb_inc;
  logic              fits;
  logic [CNT_W-1:0]  mc_inc;
  logic [BW-1:0]     addr_ext;
  logic [IDX_W-1:0]  run_start;

  always_comb begin
    ent_zero  = (map_rdata == '0);
    ent_eq    = (map_rdata == len);
    run_inc   = run + CNT_1;
    runb_inc  = run_bytes + PB_B;
    fits      = (runb_inc >= bytes_req);
    mc_inc    = (CNT_W'(modcnt + CNT_1) == len) ? '0 : CNT_W'(modcnt + CNT_1);
    addr_ext  = BW'(addr_req);
    run_start = p - IDX_W'(run);
  end

  // Map port steering
  always_comb begin
    map_we    = 1'b0;
    map_waddr = p;
    map_wdata = '0;
    map_raddr = p;
    case (state)
      S_INIT:  begin
        map_we    = 1'b1;
        map_wdata = (p == '0) ? CNT_1 : '0;
      end
      S_IDLE:  map_raddr = IDX_1;
      S_SCAN:  map_raddr = p + IDX_1;
      S_MARK:  begin
        map_we    = 1'b1;
        map_wdata = len;
      end
      S_FLEN:  map_raddr = idx;
      S_FCHK:  map_raddr = idx - IDX_1;
      S_BACK:  map_raddr = p - IDX_1;
      S_CLEAR: map_we = 1'b1;
      S_CLEAN: map_we = 1'b1;
      default: map_we = 1'b0;
    endcase
  end

  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      p     <= '0;
    end else begin
      case (state)
        // Clearing pass after reset
        S_INIT: begin
          if (p == LAST) begin
            state <= S_IDLE;
          end else begin
            p <= p + IDX_1;
          end
        end

        S_IDLE: begin
          if (start) begin
            res.alloc_address <= '0;
            res.freed_bytes   <= '0;
            bytes_req <= BW'(req.request_bytes);
            addr_req  <= req.free_address;
            case (req.action)
              ACT_ALLOC: begin
                if (req.request_bytes == '0 || BW'(req.request_bytes) > MEM_B || ONE_PAGE) begin
                  res.status <= ST_NOSPACE;
                  state      <= S_DONE;
                end else begin
                  res.status <= ST_OK;
                  p          <= IDX_1;
                  pbytes     <= PB_B;
                  run        <= '0;
                  run_bytes  <= '0;
                  state      <= S_SCAN;
                end
              end
              ACT_FREE: begin
                if (req.free_address == '0 || BW'(req.free_address) >= MEM_B) begin
                  res.status <= ST_BADADDR;
                  state      <= S_DONE;
                end else if (PB_POW2) begin
                  if ((req.free_address & OFFS_M) != '0) begin
                    res.status <= ST_BADADDR;
                    state      <= S_DONE;
                  end else begin
                    res.status <= ST_OK;
                    idx        <= IDX_W'(req.free_address >> PB_LOG);
                    state      <= S_FLEN;
                  end
                end else begin
                  res.status <= ST_OK;
                  idx        <= IDX_1;
                  pbytes     <= PB_B;
                  state      <= S_FIND;
                end
              end
              ACT_CLEAN: begin
                res.status <= ST_OK;
                if (ONE_PAGE) begin
                  state <= S_DONE;
                end else begin
                  p     <= IDX_1;
                  state <= S_CLEAN;
                end
              end
              default: begin
                res.status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end

        // First-fit scan, one entry a cycle
        S_SCAN: begin
          if (ent_zero && fits) begin
            len      <= run_inc;
            mark_end <= p;
            p        <= run_start;
            res.alloc_address <= ADDR_W'(pbytes - run_bytes);
            state    <= S_MARK;
          end else if (p == LAST) begin
            res.status <= ST_NOSPACE;
            state      <= S_DONE;
          end else begin
            p         <= p + IDX_1;
            pbytes    <= pbytes + PB_B;
            run       <= ent_zero ? run_inc : '0;
            run_bytes <= ent_zero ? runb_inc : '0;
          end
        end

        S_MARK: begin
          if (p == mark_end) begin
            state <= S_DONE;
          end else begin
            p <= p + IDX_1;
          end
        end

        // Page index by stepping byte offsets (non power of two pages)
        S_FIND: begin
          if (pbytes == addr_ext) begin
            state <= S_FLEN;
          end else if (pbytes > addr_ext) begin
            res.status <= ST_BADADDR;
            state      <= S_DONE;
          end else begin
            idx    <= idx + IDX_1;
            pbytes <= pbytes + PB_B;
          end
        end

        S_FLEN: state <= S_FCHK;

        S_FCHK: begin
          len <= map_rdata;
          if (ent_zero) begin
            res.status <= ST_BADADDR;
            state      <= S_DONE;
          end else begin
            p      <= idx - IDX_1;
            modcnt <= '0;
            state  <= S_BACK;
          end
        end

        // Count equal entries below, modulo the run length
        S_BACK: begin
          if (!ent_eq || p == '0) begin
            if ((ent_eq ? mc_inc : modcnt) == '0) begin
              p         <= idx;
              run       <= '0;
              run_bytes <= '0;
              state     <= S_CLEAR;
            end else begin
              res.status <= ST_BADADDR;
              state      <= S_DONE;
            end
          end else begin
            modcnt <= mc_inc;
            p      <= p - IDX_1;
          end
        end

        S_CLEAR: begin
          run       <= run_inc;
          run_bytes <= runb_inc;
          if (run_inc == len || p == LAST) begin
            res.freed_bytes <= FREED_W'(runb_inc);
            state           <= S_DONE;
          end else begin
            p <= p + IDX_1;
          end
        end

        S_CLEAN: begin
          if (p == LAST) begin
            state <= S_DONE;
          end else begin
            p <= p + IDX_1;
          end
        end

        S_DONE: begin
          if (done_ready) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> idle)
    else $error("request taken while sequencer busy");

  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (done && !done_ready) |=> done)
    else $error("result dropped before hand-off");

  a_mark_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK) |-> (map_wdata != '0))
    else $error("run marked with zero length");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && res.status != ST_OK) |-> (res.alloc_address == '0 && res.freed_bytes == '0))
    else $error("failed request carries nonzero result fields");

endmodule

// ===== rtl/core/page_run_allocator_top.sv =====
// Alloc scans pages, then marks the run; free compares the entries below the run, then
// clears the run (after a page index walk when pages are not a power of two); clean walks
// pages 1 up; bad requests skip the walks. One word in flight at a time, paced by
// the single read and write port of the page map. Results sit in an output register.
// Reset (rst, synchronous) runs a clearing pass that sets page 0 to 1 and all other
// pages to 0; no request is taken meanwhile.
module page_run_allocator_top #(
  parameter int PAGE_BYTES = pra_pkg::PAGE_BYTES_DEF,
  parameter int MEM_BYTES  = pra_pkg::MEM_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  pra_req_if.sink      req,
  pra_res_if.source    rsp
);

  import pra_pkg::*;

  localparam int NPAGES = MEM_BYTES / PAGE_BYTES;
  localparam int IDX_W  = (NPAGES > 1) ? $clog2(NPAGES) : 1;
  localparam int CNT_W  = $clog2(NPAGES + 1);

  logic             eng_idle;
  logic             eng_done;
  logic             done_ready;
  logic             start;
  req_t             eng_req;
  res_t             eng_res;
  res_t             out_res;
  logic             out_valid;
  logic             map_we;
  logic [IDX_W-1:0] map_waddr;
  logic [CNT_W-1:0] map_wdata;
  logic [IDX_W-1:0] map_raddr;
  logic [CNT_W-1:0] map_rdata;

  // Request side
  assign req.ready = eng_idle;
  assign start     = req.valid && eng_idle;
  assign eng_req   = '{action: req.action, request_bytes: req.request_bytes,
                       free_address: req.free_address};

  // Output register frees the sequencer as soon as a word is parked
  assign done_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_done && done_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_done && done_ready) begin
      out_res <= eng_res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_res.status;
  assign rsp.alloc_address = out_res.alloc_address;
  assign rsp.freed_bytes   = out_res.freed_bytes;

  pra_seq #(
    .PAGE_BYTES (PAGE_BYTES),
    .MEM_BYTES  (MEM_BYTES),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req        (eng_req),
    .idle       (eng_idle),
    .done       (eng_done),
    .done_ready (done_ready),
    .res        (eng_res),
    .map_we     (map_we),
    .map_waddr  (map_waddr),
    .map_wdata  (map_wdata),
    .map_raddr  (map_raddr),
    .map_rdata  (map_rdata)
  );

  pra_map_ram #(
    .DEPTH  (NPAGES),
    .IDX_W  (IDX_W),
    .DATA_W (CNT_W)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

endmodule

// ===== tb/page_run_allocator_top_tb.sv =====
`timescale 1ns / 1ps

module page_run_allocator_top_tb;
  import pra_pkg::*;

  localparam int PAGE         = PAGE_BYTES_DEF;
  localparam int MEM          = MEM_BYTES_DEF;
  localparam int NPAGES       = MEM_BYTES_DEF / PAGE_BYTES_DEF;
  localparam int RANDOM_WORDS = 700;
  localparam int HOLD_CYCLES  = 3000;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_REPORTS  = 100;
  // action code the block leaves undecoded
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  // Page map mirror plus the queue of results still owed by the block
  class allocator_scoreboard;
    bit [9:0] page_map [NPAGES];
    res_t     expected_results [$];
    int       errors;
    int       results_checked;

    function new();
      foreach (page_map[p]) page_map[p] = '0;
      page_map[0] = 10'd1;
      errors = 0;
      results_checked = 0;
    endfunction

    // first-fit search upwards from page 1
    function res_t take_run(logic [REQ_W-1:0] bytes);
      res_t r;
      int   need, run, p, start;
      r = '0;
      r.status = ST_OK;
      run = 0;
      if (bytes == 0 || bytes > MEM) begin
        r.status = ST_NOSPACE;
        return r;
      end
      need = (int'(bytes) + PAGE - 1) / PAGE;
      for (p = 1; p < NPAGES; p++) begin
        if (page_map[p] == 0) run++;
        else run = 0;
        if (run == need) break;
      end
      if (p >= NPAGES) begin
        r.status = ST_NOSPACE;
        return r;
      end
      start = p + 1 - run;
      for (int k = start; k <= p; k++) page_map[k] = 10'(run);
      r.alloc_address = ADDR_W'(start * PAGE);
      return r;
    endfunction

    // release a run, but only from its first page
    function res_t release_run(logic [ADDR_W-1:0] addr);
      res_t r;
      int   idx, len, cnt, cleared;
      r = '0;
      r.status = ST_BADADDR;
      cnt = 0;
      cleared = 0;
      if (addr == 0 || (addr % PAGE) != 0 || addr >= MEM) return r;
      idx = addr / PAGE;
      len = int'(page_map[idx]);
      if (len == 0) return r;
      for (int j = idx - 1; j >= 0 && page_map[j] == len; j--) cnt++;
      if ((cnt % len) != 0) return r;
      for (int k = 0; k < len && idx + k < NPAGES; k++) begin
        page_map[idx + k] = '0;
        cleared++;
      end
      r.status = ST_OK;
      r.freed_bytes = FREED_W'(cleared * PAGE);
      return r;
    endfunction

    function res_t note_request(req_t w);
      res_t r;
      r = '0;
      r.status = ST_OK;
      case (w.action)
        ACT_ALLOC: r = take_run(w.request_bytes);
        ACT_FREE:  r = release_run(w.free_address);
        ACT_CLEAN: for (int p = 1; p < NPAGES; p++) page_map[p] = '0;
        default:   ;
      endcase
      expected_results.push_back(r);
      return r;
    endfunction

    task report(string msg);
      if (errors < MAX_REPORTS) $display("%0t ns  result %0d: %s", $time, results_checked, msg);
      errors++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected word, status %0d", got.status));
        results_checked++;
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.alloc_address !== want.alloc_address)
        report($sformatf("alloc_address %0h, want %0h", got.alloc_address, want.alloc_address));
      if (got.freed_bytes !== want.freed_bytes)
        report($sformatf("freed_bytes %0h, want %0h", got.freed_bytes, want.freed_bytes));
      results_checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  pra_req_if req_ch ();
  pra_res_if res_ch ();

  page_run_allocator_top uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (res_ch)
  );

  allocator_scoreboard sb = new();
  bit [ADDR_W-1:0] live_runs [$];
  int burst_left = 0;
  int cycle_count = 0;

  always #2 clk = ~clk;

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("page_run_allocator_top regression: fail");
    $finish;
  end

  function automatic req_t make_word(logic [ACTION_W-1:0] action, logic [REQ_W-1:0] bytes,
                                     logic [ADDR_W-1:0] addr);
    req_t w;
    w.action = action;
    w.request_bytes = bytes;
    w.free_address = addr;
    return w;
  endfunction

  // Offer one word, in bursts with random gaps, and record it once taken
  task automatic send_word(req_t w);
    res_t e;
    int   gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid <= 1'b1;
    req_ch.action <= w.action;
    req_ch.request_bytes <= w.request_bytes;
    req_ch.free_address <= w.free_address;
    do @(posedge clk); while (!req_ch.ready);
    e = sb.note_request(w);
    if (w.action == ACT_ALLOC && e.status == ST_OK) live_runs.push_back(e.alloc_address);
    if (w.action == ACT_CLEAN) live_runs.delete();
  endtask

  // Result side: own stall pattern, one long hold-off to back the block up
  initial begin
    res_t got;
    int   mode, mode_left, phase;
    bit   held, nxt;
    mode = 0;
    mode_left = 0;
    phase = 0;
    held = 1'b0;
    res_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) begin
        got.status = status_t'(res_ch.status);
        got.alloc_address = res_ch.alloc_address;
        got.freed_bytes = res_ch.freed_bytes;
        sb.check_result(got);
      end
      if (!held && sb.results_checked >= 150) begin
        held = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_ch.ready <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(50, 400);
        end
        mode_left--;
        phase++;
        case (mode)
          0: nxt = 1'b1;
          1: nxt = 1'($urandom_range(0, 1));
          2: nxt = (phase % 4 == 0);
          default: nxt = ($urandom_range(0, 9) != 0);
        endcase
        res_ch.ready <= nxt;
      end
    end
  end

  // Stimulus
  initial begin
    int r, sel, idx;
    logic [REQ_W-1:0]  bytes;
    logic [ADDR_W-1:0] addr;

    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.action <= ACT_ALLOC;
    req_ch.request_bytes <= '0;
    req_ch.free_address <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // size checks and a first few runs
    send_word(make_word(ACT_ALLOC, '0, '0));
    send_word(make_word(ACT_ALLOC, REQ_W'(MEM + 1), '0));
    send_word(make_word(ACT_ALLOC, 19'h7FFFF, '0));
    send_word(make_word(ACT_ALLOC, 19'd1, '0));
    send_word(make_word(ACT_ALLOC, REQ_W'(PAGE), '0));
    send_word(make_word(ACT_ALLOC, REQ_W'(PAGE + 1), '0));
    // bad addresses: zero, misaligned, all ones, mid-run, free page; then a good free
    send_word(make_word(ACT_FREE, '0, '0));
    send_word(make_word(ACT_FREE, '0, ADDR_W'(PAGE + 1)));
    send_word(make_word(ACT_FREE, '0, 18'h3FFFF));
    send_word(make_word(ACT_FREE, '0, ADDR_W'(4 * PAGE)));
    send_word(make_word(ACT_FREE, '0, ADDR_W'(100 * PAGE)));
    send_word(make_word(ACT_FREE, '0, ADDR_W'(3 * PAGE)));
    // whole memory never fits since page 0 is reserved
    send_word(make_word(ACT_ALLOC, REQ_W'(MEM), '0));
    send_word(make_word(ACT_UNUSED, '0, '0));
    send_word(make_word(ACT_CLEAN, '0, '0));
    // largest run, then no room left
    send_word(make_word(ACT_ALLOC, REQ_W'(MEM - PAGE), '0));
    send_word(make_word(ACT_FREE, '0, ADDR_W'((NPAGES - 1) * PAGE)));
    send_word(make_word(ACT_ALLOC, 19'd1, '0));
    send_word(make_word(ACT_FREE, '0, ADDR_W'(PAGE)));
    send_word(make_word(ACT_ALLOC, 19'd1, '0));
    send_word(make_word(ACT_FREE, '0, ADDR_W'(PAGE)));
    send_word(make_word(ACT_CLEAN, '0, '0));

    // Random mix: mostly small runs and frees of live runs, some noise
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      r = $urandom_range(0, 99);
      sel = $urandom_range(0, 99);
      if (r < 48) begin
        if (sel < 75) bytes = REQ_W'($urandom_range(1, 4 * PAGE));
        else if (sel < 90) bytes = REQ_W'($urandom_range(1, 64 * PAGE));
        else if (sel < 95) bytes = REQ_W'($urandom_range(1, MEM));
        else if (sel < 98) bytes = REQ_W'($urandom_range(MEM + 1, 19'h7FFFF));
        else bytes = '0;
        send_word(make_word(ACT_ALLOC, bytes, ADDR_W'($urandom)));
      end else if (r < 94) begin
        if (sel < 75 && live_runs.size() != 0) begin
          idx = $urandom_range(0, live_runs.size() - 1);
          addr = live_runs[idx];
          live_runs.delete(idx);
        end else begin
          case (sel % 4)
            0: addr = ADDR_W'($urandom);
            1: addr = ADDR_W'($urandom_range(0, NPAGES - 1) * PAGE);
            2: addr = (live_runs.size() != 0) ?
                      ADDR_W'(live_runs[$urandom_range(0, live_runs.size() - 1)] + PAGE) :
                      ADDR_W'($urandom_range(1, NPAGES - 1) * PAGE);
            default: addr = ADDR_W'($urandom_range(1, NPAGES - 1) * PAGE
                                    + $urandom_range(1, PAGE - 1));
          endcase
        end
        send_word(make_word(ACT_FREE, REQ_W'($urandom), addr));
      end else if (r < 97) begin
        send_word(make_word(ACT_CLEAN, REQ_W'($urandom), ADDR_W'($urandom)));
      end else begin
        send_word(make_word(ACT_UNUSED, REQ_W'($urandom), ADDR_W'($urandom)));
      end
    end
    req_ch.valid <= 1'b0;

    // drain, then a short quiet spell for stray words
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("page_run_allocator_top regression: pass");
    else $display("page_run_allocator_top regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pra_pkg.sv
rtl/core/pra_if.sv
rtl/core/pra_map_ram.sv
rtl/core/pra_seq.sv
rtl/core/page_run_allocator_top.sv
tb/page_run_allocator_top_tb.sv
